>>> hdl/hhsp_pkg.sv
// Shared constants for the hydro half-step predictor.
`default_nettype none
package hhsp_pkg;
  localparam int DIMENSIONS_DEF  = 3;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 10;
  localparam int LANES           = 3;
  localparam int DT_WIDTH        = 16;
endpackage
`default_nettype wire

>>> hdl/hydro_half_step_predictor.sv
// Half-step predictor for one grid cell: density and velocity, saturated fixed point.
//
// Fully pipelined: one cell is accepted per cycle while the output does not stall, and a
// new cell can enter before earlier ones are through. The depth is set by the
// energy/density quotient, which runs through a restoring divider that resolves one
// quotient bit per stage, three lanes side by side. Stalls on the output hold the
// pipeline without loss; empty stages still fill while the output waits. time_step is
// written on the cfg channel, which is always ready, and is read by the multiply stage.
`default_nettype none
module hydro_half_step_predictor #(
  parameter int DIMENSIONS  = hhsp_pkg::DIMENSIONS_DEF,
  parameter int VALUE_WIDTH = hhsp_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = hhsp_pkg::FRAC_BITS_DEF,
  localparam int IN_TW  = ((21 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((4 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [hhsp_pkg::DT_WIDTH-1:0] cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // density, energy, density_source, velocity_packed, density_slope_packed,
  // velocity_slope_x, velocity_slope_y, velocity_slope_z, velocity_source_packed
  input  wire logic [IN_TW-1:0]     in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // density_predicted, velocity_predicted_packed
  output logic [OUT_TW-1:0]         out_tdata,
  // range_flag
  output logic [0:0]                out_tuser
);
  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int L   = hhsp_pkg::LANES;
  localparam int DTW = hhsp_pkg::DT_WIDTH;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + F + 3;
  localparam int NB  = 2 * W - 1 + F;
  localparam int RW  = 2 * F + W + 4;
  localparam int HW  = RW - F;
  localparam int CW  = ((SW > RW) ? SW : RW) + 1;
  localparam int MW  = HW + DTW + 1;
  localparam int IW  = MW + 2;
  localparam int S_QUO = NB + 2;
  localparam int S_MUL = NB + 3;
  localparam int S_OUT = NB + 4;
  localparam int NS    = NB + 5;

  localparam logic signed [CW-1:0] CAP_P = CW'(1) <<< (2 * F + W + 2);
  localparam logic signed [IW-1:0] VMAX  = (IW'(1) <<< (W - 1)) - IW'(1);
  localparam logic signed [IW-1:0] VMIN  = -(IW'(1) <<< (W - 1));
  localparam logic [F:0] LO_MASK = (F + 1)'((1 << F) - 1);

  logic [DTW-1:0] time_step_r;
  logic [NS-1:0]  v_r;
  logic [NS:0]    rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= '0;
    end else if (cfg_valid) begin
      time_step_r <= cfg_data;
    end
  end

  // stage i takes new contents when empty or when its successor moves
  always_comb begin
    rdy[NS] = out_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end
  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // input unpacking; velocity, density-slope and velocity-slope-row lanes at or beyond DIMENSIONS forced to zero
  logic signed [W-1:0] rho_i, e_i, src_i;
  logic signed [W-1:0] vel_i [L];
  logic signed [W-1:0] srho_i [L];
  logic signed [W-1:0] vsrc_i [L];
  logic signed [W-1:0] vs_i [L][L];  // [row n][component p]

  always_comb begin
    rho_i = $signed(in_tdata[0 +: W]);
    e_i   = $signed(in_tdata[W +: W]);
    src_i = $signed(in_tdata[2*W +: W]);
    for (int c = 0; c < L; c++) begin
      vel_i[c]  = (c < DIMENSIONS) ? $signed(in_tdata[3*W + c*W +: W]) : '0;
      srho_i[c] = (c < DIMENSIONS) ? $signed(in_tdata[6*W + c*W +: W]) : '0;
      vsrc_i[c] = $signed(in_tdata[18*W + c*W +: W]);
      for (int n = 0; n < L; n++) begin
        vs_i[n][c] = (n < DIMENSIONS) ? $signed(in_tdata[(9 + 3*n)*W + c*W +: W]) : '0;
      end
    end
  end

  // carried through the whole pipeline up to the multiply stage
  logic signed [W-1:0] rho_c  [S_MUL+1];
  logic signed [W-1:0] vel_c  [S_MUL+1][L];
  logic                zero_c [S_MUL+1];

  // stage 0: products
  logic signed [W-1:0]  src_r;
  logic signed [W-1:0]  vsrc_r [L];
  logic signed [PW-1:0] adv_r  [L][L];
  logic signed [PW-1:0] conv_r [L];
  logic signed [PW-1:0] comp_r [L];
  logic signed [PW-1:0] en_r   [L];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rho_c[0]  <= rho_i;
      zero_c[0] <= (rho_i == '0);
      src_r     <= src_i;
      for (int p = 0; p < L; p++) begin
        vel_c[0][p] <= vel_i[p];
        vsrc_r[p]   <= vsrc_i[p];
        conv_r[p]   <= vel_i[p] * srho_i[p];
        comp_r[p]   <= rho_i * vs_i[p][p];
        en_r[p]     <= e_i * srho_i[p];
        for (int n = 0; n < L; n++) begin
          adv_r[p][n] <= vel_i[n] * vs_i[n][p];
        end
      end
    end
  end

  for (genvar st = 1; st <= S_MUL; st++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rdy[st]) begin
        rho_c[st]  <= rho_c[st-1];
        vel_c[st]  <= vel_c[st-1];
        zero_c[st] <= zero_c[st-1];
      end
    end
  end

  // divider span: channel 0 is the density rate, channel p+1 velocity lane p
  logic signed [SW-1:0] base_c [1:S_QUO-1][L+1];
  logic                 neg_c  [1:S_QUO-1][L];
  logic [W-1:0]         d_c    [1:S_QUO-1];
  logic [W-1:0]         rem_c  [1:S_QUO-1][L];
  logic [NB-1:0]        q_c    [1:S_QUO-1][L];

  // stage 1: rate sums and divider setup
  logic signed [SW-1:0] base_nxt [L+1];
  logic                 neg_nxt  [L];
  logic [NB-1:0]        num_nxt  [L];
  logic [PW-1:0]        en_abs   [L];
  logic [W-1:0]         d_nxt;

  always_comb begin
    base_nxt[0] = SW'(src_r) <<< F;
    for (int n = 0; n < L; n++) begin
      base_nxt[0] = base_nxt[0] - SW'(conv_r[n]) - SW'(comp_r[n]);
    end
    for (int p = 0; p < L; p++) begin
      base_nxt[p+1] = SW'(vsrc_r[p]) <<< F;
      for (int n = 0; n < L; n++) begin
        base_nxt[p+1] = base_nxt[p+1] - SW'(adv_r[p][n]);
      end
      en_abs[p]  = en_r[p][PW-1] ? PW'(-en_r[p]) : PW'(en_r[p]);
      num_nxt[p] = NB'({en_abs[p][PW-2:0], {F{1'b0}}});
      neg_nxt[p] = en_r[p][PW-1] ^ rho_c[0][W-1];
    end
    d_nxt = rho_c[0][W-1] ? W'(-rho_c[0]) : W'(rho_c[0]);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      base_c[1] <= base_nxt;
      neg_c[1]  <= neg_nxt;
      d_c[1]    <= d_nxt;
      for (int p = 0; p < L; p++) begin
        rem_c[1][p] <= '0;
        q_c[1][p]   <= num_nxt[p];
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NB; k++) begin : g_div
    logic [W:0]    rsh [L];
    logic          ge  [L];
    logic [W-1:0]  rem_nxt [L];
    logic [NB-1:0] q_nxt   [L];

    always_comb begin
      for (int p = 0; p < L; p++) begin
        rsh[p]     = {rem_c[1+k][p], q_c[1+k][p][NB-1]};
        ge[p]      = (rsh[p] >= {1'b0, d_c[1+k]});
        rem_nxt[p] = ge[p] ? W'(rsh[p] - {1'b0, d_c[1+k]}) : W'(rsh[p]);
        q_nxt[p]   = {q_c[1+k][p][NB-2:0], ge[p]};
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[2+k]) begin
        base_c[2+k] <= base_c[1+k];
        neg_c[2+k]  <= neg_c[1+k];
        d_c[2+k]    <= d_c[1+k];
        rem_c[2+k]  <= rem_nxt;
        q_c[2+k]    <= q_nxt;
      end
    end
  end

  // quotient stage: apply energy term, clamp, split into hi and lo
  logic signed [HW-1:0] hi_r [L+1];
  logic [F:0]           lo_r [L+1];
  logic signed [SW-1:0] rate_q [L+1];
  logic signed [SW-1:0] term_q;
  logic signed [CW-1:0] rate_x;
  logic signed [RW-1:0] rate_cl [L+1];

  always_comb begin
    rate_q[0] = base_c[S_QUO-1][0];
    for (int p = 0; p < L; p++) begin
      term_q = SW'({1'b0, q_c[S_QUO-1][p]});
      if (neg_c[S_QUO-1][p]) term_q = -term_q;
      if (zero_c[S_QUO-1])   term_q = '0;
      rate_q[p+1] = base_c[S_QUO-1][p+1] - term_q;
    end
    for (int c = 0; c <= L; c++) begin
      rate_x = CW'(rate_q[c]);
      if (rate_x > CAP_P)       rate_x = CAP_P;
      else if (rate_x < -CAP_P) rate_x = -CAP_P;
      rate_cl[c] = RW'(rate_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_QUO]) begin
      for (int c = 0; c <= L; c++) begin
        hi_r[c] <= HW'(rate_cl[c] >>> F);
        lo_r[c] <= rate_cl[c][F:0] & LO_MASK;
      end
    end
  end

  // multiply stage: dt times hi and lo parts
  logic signed [MW-1:0]  dthi_r [L+1];
  logic [DTW:0]          dtlo_r [L+1];
  logic [DTW+F:0]        dtlo_full [L+1];

  always_comb begin
    for (int c = 0; c <= L; c++) begin
      dtlo_full[c] = lo_r[c] * time_step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_MUL]) begin
      for (int c = 0; c <= L; c++) begin
        dthi_r[c] <= $signed({1'b0, time_step_r}) * hi_r[c];
        dtlo_r[c] <= dtlo_full[c][DTW+F:F];
      end
    end
  end

  // output stage: increment, add to old value, saturate
  logic signed [IW-1:0] inner [L+1];
  logic signed [IW-1:0] sum_o [L+1];
  logic signed [W-1:0]  old_o [L+1];
  logic [W-1:0]         res_o [L+1];
  logic                 sat_o [L+1];
  logic [W-1:0]         dens_nxt;
  logic [L*W-1:0]       vel_nxt;
  logic                 flag_nxt;
  logic [W-1:0]         dens_r;
  logic [L*W-1:0]       vel_r;
  logic                 flag_r;

  always_comb begin
    old_o[0] = rho_c[S_MUL];
    for (int p = 0; p < L; p++) old_o[p+1] = vel_c[S_MUL][p];
    flag_nxt = zero_c[S_MUL];
    vel_nxt  = '0;
    for (int c = 0; c <= L; c++) begin
      inner[c] = IW'(dthi_r[c]) + IW'($signed({1'b0, dtlo_r[c]}));
      sum_o[c] = IW'(old_o[c]) + (inner[c] >>> (F + 1));
      sat_o[c] = 1'b0;
      if (sum_o[c] > VMAX) begin
        res_o[c] = VMAX[W-1:0];
        sat_o[c] = 1'b1;
      end else if (sum_o[c] < VMIN) begin
        res_o[c] = VMIN[W-1:0];
        sat_o[c] = 1'b1;
      end else begin
        res_o[c] = sum_o[c][W-1:0];
      end
    end
    dens_nxt = res_o[0];
    flag_nxt = flag_nxt | sat_o[0];
    for (int p = 0; p < L; p++) begin
      if (p < DIMENSIONS) begin
        vel_nxt[p*W +: W] = res_o[p+1];
        flag_nxt = flag_nxt | sat_o[p+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      dens_r <= dens_nxt;
      vel_r  <= vel_nxt;
      flag_r <= flag_nxt;
    end
  end

  assign out_tvalid = v_r[S_OUT];
  assign out_tdata  = OUT_TW'({vel_r, dens_r});
  assign out_tuser  = flag_r;

  // an empty output stage means nothing can hold the input back
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  a_accept_fills_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted transaction not captured");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && (d_c[2] != '0) |-> (rem_c[2][0] < d_c[2]))
    else $error("divider remainder out of range");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S_MUL] && zero_c[S_MUL] && rdy[S_OUT] |=> out_tuser[0])
    else $error("zero density not flagged");
endmodule
`default_nettype wire
